>>> rtl/adag_pkg.sv
// ----------------------------------------------------------------------------
// adag_pkg
// shared widths, word layouts and op codes of the array address generator
// ----------------------------------------------------------------------------
package adag_pkg;

    localparam int WORD_W  = 32;
    localparam int ID_IN_W = 4;
    localparam int ELEM_W  = 16;
    localparam int TOTAL_W = 4;
    localparam int POS_W   = 3;
    localparam int OP_W    = 2;

    // input word layout
    localparam int ID_LSB    = 0;
    localparam int BASE_LSB  = ID_LSB + ID_IN_W;
    localparam int ELEM_LSB  = BASE_LSB + WORD_W;
    localparam int TOTAL_LSB = ELEM_LSB + ELEM_W;
    localparam int POS_LSB   = TOTAL_LSB + TOTAL_W;
    localparam int LO_LSB    = POS_LSB + POS_W;
    localparam int HI_LSB    = LO_LSB + WORD_W;
    localparam int SUB_LSB   = HI_LSB + WORD_W;
    localparam int IN_BITS   = SUB_LSB + WORD_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    // result word layout
    localparam int OUT_BITS   = ID_IN_W + WORD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_DECL  = 2'd0;
    localparam logic [OP_W-1:0] OP_BOUND = 2'd1;
    localparam logic [OP_W-1:0] OP_REF   = 2'd2;

endpackage

>>> rtl/adag_ram.sv
// ----------------------------------------------------------------------------
// adag_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module adag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/adag_mul.sv
// ----------------------------------------------------------------------------
// adag_mul
// shared 32x32 multiplier, low product word registered
// ----------------------------------------------------------------------------
module adag_mul
    import adag_pkg::*;
(
    input  logic              aclk,
    input  logic [WORD_W-1:0] mul_a,
    input  logic [WORD_W-1:0] mul_b,
    output logic [WORD_W-1:0] product
);

    logic [WORD_W-1:0] product_reg;
    logic [WORD_W-1:0] product_next;

    // only the low word is kept, arithmetic wraps
    assign product_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

>>> rtl/array_descriptor_address_generator_top.sv
// ----------------------------------------------------------------------------
// array_descriptor_address_generator_top
// row-major array descriptor table and element address generator
// ----------------------------------------------------------------------------
// One word is taken at a time; s_tready is high only while the sequencer is
// idle, and a finished address waits in the output register without holding
// up the next word, unless a second address finishes before the first one has
// been taken, in which case the sequencer holds until the output register
// frees up. All products go through one shared 32x32 multiplier with a
// registered result, and all tables sit in rams with registered reads, so
// the cost of a word is set by that multiplier and those read ports: a
// declaration zeroes the bounds of the array one dimension a cycle, the last
// bound walks the stride chain with two products per dimension, and a
// subscript takes one product, plus an emit step when it completes an
// address. Arithmetic wraps modulo 2^32.
// ----------------------------------------------------------------------------
module array_descriptor_address_generator_top
    import adag_pkg::*;
#(
    parameter int MAX_ARRAYS = 16,
    parameter int MAX_DIMS   = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // array_id, base_addr, elem_bytes, dim_total, dim_pos, low_bound,
    // high_bound, subscript, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // ref_array, elem_address, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int ID_W  = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W = $clog2(MAX_DIMS + 1);
    localparam int HDR_W = WORD_W + ELEM_W + CNT_W;
    localparam int BND_W = 2 * WORD_W;
    localparam int DIM_DEPTH = MAX_ARRAYS * (2 ** DIM_W);
    localparam logic [DIM_W-1:0] K_LAST = DIM_W'(MAX_DIMS - 1);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_LOOKUP = 13'b0000000000010,
        ST_CHECK  = 13'b0000000000100,
        ST_CLEAR  = 13'b0000000001000,
        ST_BINIT  = 13'b0000000010000,
        ST_BORG0  = 13'b0000000100000,
        ST_BREAD  = 13'b0000001000000,
        ST_BMULX  = 13'b0000010000000,
        ST_BSTR   = 13'b0000100000000,
        ST_BORG   = 13'b0001000000000,
        ST_BFIN   = 13'b0010000000000,
        ST_RACC   = 13'b0100000000000,
        ST_REMIT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // latched input word
    logic [OP_W-1:0]    op_reg;
    logic [ID_IN_W-1:0] id_reg;
    logic [WORD_W-1:0]  base_in_reg;
    logic [ELEM_W-1:0]  elem_in_reg;
    logic [TOTAL_W-1:0] total_in_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [WORD_W-1:0]  lo_reg;
    logic [WORD_W-1:0]  hi_reg;
    logic [WORD_W-1:0]  sub_reg;

    logic [DIM_W-1:0]      k_reg, k_next;
    logic [WORD_W-1:0]     stride_reg, stride_next;
    logic [WORD_W-1:0]     org_reg, org_next;
    logic [WORD_W-1:0]     accum_reg, accum_next;
    logic [MAX_ARRAYS-1:0] decl_reg, decl_next;
    logic [MAX_ARRAYS-1:0] ready_reg, ready_next;
    logic                  m_valid_reg, m_valid_next;
    logic [ID_IN_W-1:0]    m_ref_reg, m_ref_next;
    logic [WORD_W-1:0]     m_addr_reg, m_addr_next;

    logic                 s_accept;
    logic [ID_W-1:0]      id_idx;
    logic [DIM_W-1:0]     pos_idx;
    logic                 id_ok;
    logic [CNT_W-1:0]     cnt_sat;
    logic [CNT_W-1:0]     n_cur;
    logic                 pos_ok;
    logic                 pos_last;
    logic [DIM_W-1:0]     k_top;
    logic [WORD_W-1:0]    elem_word;

    logic                 hdr_wr_en, hdr_rd_en;
    logic [HDR_W-1:0]     hdr_wdata, hdr_rdata;
    logic                 bnd_wr_en, bnd_rd_en;
    logic [ID_W+DIM_W-1:0] bnd_wr_addr, bnd_rd_addr;
    logic [BND_W-1:0]     bnd_wdata, bnd_rdata;
    logic                 str_wr_en, str_rd_en;
    logic [ID_W+DIM_W-1:0] str_wr_addr;
    logic [WORD_W-1:0]    str_wdata, str_rdata;
    logic                 org_wr_en, org_rd_en;
    logic [WORD_W-1:0]    org_rdata;

    logic [WORD_W-1:0]    mul_a, mul_b, product;

    logic [WORD_W-1:0]    hdr_base;
    logic [ELEM_W-1:0]    hdr_elem;
    logic [CNT_W-1:0]     hdr_cnt;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign id_idx   = ID_W'(id_reg);
    assign pos_idx  = DIM_W'(pos_reg);
    assign id_ok    = 32'(id_reg) < MAX_ARRAYS;
    assign cnt_sat  = (32'(total_in_reg) > MAX_DIMS) ? CNT_W'(MAX_DIMS) : CNT_W'(total_in_reg);

    assign hdr_base = hdr_rdata[WORD_W-1:0];
    assign hdr_elem = hdr_rdata[WORD_W +: ELEM_W];
    assign hdr_cnt  = hdr_rdata[WORD_W + ELEM_W +: CNT_W];

    // undeclared arrays count as zero dimensions
    assign n_cur    = decl_reg[id_idx] ? hdr_cnt : '0;
    assign pos_ok   = 32'(pos_reg) < 32'(n_cur);
    assign pos_last = (32'(pos_reg) + 32'd1) == 32'(n_cur);
    assign k_top    = DIM_W'(n_cur - CNT_W'(1));
    assign elem_word = WORD_W'(hdr_elem);

    assign hdr_wdata   = {cnt_sat, elem_in_reg, base_in_reg};
    assign bnd_rd_addr = (state_reg == ST_BMULX) ? {id_idx, k_reg - DIM_W'(1)} : {id_idx, k_reg};

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        stride_next  = stride_reg;
        org_next     = org_reg;
        accum_next   = accum_reg;
        decl_next    = decl_reg;
        ready_next   = ready_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_ref_next   = m_ref_reg;
        m_addr_next  = m_addr_reg;
        hdr_wr_en    = 1'b0;
        hdr_rd_en    = 1'b0;
        bnd_wr_en    = 1'b0;
        bnd_wr_addr  = {id_idx, k_reg};
        bnd_wdata    = '0;
        bnd_rd_en    = 1'b0;
        str_wr_en    = 1'b0;
        str_wr_addr  = {id_idx, k_reg};
        str_wdata    = product;
        str_rd_en    = 1'b0;
        org_wr_en    = 1'b0;
        org_rd_en    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                hdr_rd_en = 1'b1;
                str_rd_en = 1'b1;
                org_rd_en = 1'b1;
                k_next    = '0;
                priority if (!id_ok) begin
                    state_next = ST_IDLE;
                end else if (op_reg == OP_DECL) begin
                    state_next = ST_CLEAR;
                end else if (op_reg == OP_BOUND || op_reg == OP_REF) begin
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                // zero the bounds of the array, one dimension a cycle
                bnd_wr_en   = 1'b1;
                bnd_wr_addr = {id_idx, k_reg};
                bnd_wdata   = '0;
                if (k_reg == '0) begin
                    hdr_wr_en          = 1'b1;
                    decl_next[id_idx]  = 1'b1;
                    ready_next[id_idx] = 1'b0;
                end
                if (k_reg == K_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next = k_reg + DIM_W'(1);
                end
            end
            ST_CHECK: begin
                priority if (!pos_ok) begin
                    state_next = ST_IDLE;
                end else if (op_reg == OP_BOUND) begin
                    bnd_wr_en   = 1'b1;
                    bnd_wr_addr = {id_idx, pos_idx};
                    bnd_wdata   = {lo_reg, hi_reg - lo_reg + WORD_W'(1)};
                    state_next  = pos_last ? ST_BINIT : ST_IDLE;
                end else if (!ready_reg[id_idx]) begin
                    state_next = ST_IDLE;
                end else begin
                    mul_a      = str_rdata;
                    mul_b      = sub_reg;
                    state_next = ST_RACC;
                end
            end
            ST_BINIT: begin
                str_wr_en   = 1'b1;
                str_wr_addr = {id_idx, k_top};
                str_wdata   = elem_word;
                stride_next = elem_word;
                mul_a       = elem_word;
                mul_b       = lo_reg;
                k_next      = k_top;
                state_next  = ST_BORG0;
            end
            ST_BORG0: begin
                org_next   = hdr_base - product;
                state_next = (k_reg == '0) ? ST_BFIN : ST_BREAD;
            end
            ST_BREAD: begin
                // extent of dimension k
                bnd_rd_en  = 1'b1;
                state_next = ST_BMULX;
            end
            ST_BMULX: begin
                mul_a      = stride_reg;
                mul_b      = bnd_rdata[WORD_W-1:0];
                bnd_rd_en  = 1'b1;
                state_next = ST_BSTR;
            end
            ST_BSTR: begin
                stride_next = product;
                str_wr_en   = 1'b1;
                str_wr_addr = {id_idx, k_reg - DIM_W'(1)};
                str_wdata   = product;
                mul_a       = product;
                mul_b       = bnd_rdata[WORD_W +: WORD_W];
                k_next      = k_reg - DIM_W'(1);
                state_next  = ST_BORG;
            end
            ST_BORG: begin
                org_next   = org_reg - product;
                state_next = (k_reg == '0) ? ST_BFIN : ST_BREAD;
            end
            ST_BFIN: begin
                org_wr_en          = 1'b1;
                ready_next[id_idx] = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_RACC: begin
                accum_next = ((pos_reg == '0) ? org_rdata : accum_reg) + product;
                state_next = pos_last ? ST_REMIT : ST_IDLE;
            end
            ST_REMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_ref_next   = id_reg;
                    m_addr_next  = accum_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            decl_reg    <= '0;
            ready_reg   <= '0;
            accum_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            decl_reg    <= decl_next;
            ready_reg   <= ready_next;
            accum_reg   <= accum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg       <= s_tuser;
            id_reg       <= s_tdata[ID_LSB +: ID_IN_W];
            base_in_reg  <= s_tdata[BASE_LSB +: WORD_W];
            elem_in_reg  <= s_tdata[ELEM_LSB +: ELEM_W];
            total_in_reg <= s_tdata[TOTAL_LSB +: TOTAL_W];
            pos_reg      <= s_tdata[POS_LSB +: POS_W];
            lo_reg       <= s_tdata[LO_LSB +: WORD_W];
            hi_reg       <= s_tdata[HI_LSB +: WORD_W];
            sub_reg      <= s_tdata[SUB_LSB +: WORD_W];
        end
        k_reg      <= k_next;
        stride_reg <= stride_next;
        org_reg    <= org_next;
        m_ref_reg  <= m_ref_next;
        m_addr_reg <= m_addr_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, m_addr_reg, m_ref_reg};

    adag_mul u_mul (
        .aclk    (aclk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    adag_ram #(
        .WIDTH (HDR_W),
        .DEPTH (MAX_ARRAYS),
        .ADDR_W(ID_W)
    ) u_hdr_ram (
        .aclk    (aclk),
        .wr_en   (hdr_wr_en),
        .wr_addr (id_idx),
        .wr_data (hdr_wdata),
        .rd_en   (hdr_rd_en),
        .rd_addr (id_idx),
        .rd_data (hdr_rdata)
    );

    adag_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ARRAYS),
        .ADDR_W(ID_W)
    ) u_org_ram (
        .aclk    (aclk),
        .wr_en   (org_wr_en),
        .wr_addr (id_idx),
        .wr_data (org_reg),
        .rd_en   (org_rd_en),
        .rd_addr (id_idx),
        .rd_data (org_rdata)
    );

    adag_ram #(
        .WIDTH (BND_W),
        .DEPTH (DIM_DEPTH),
        .ADDR_W(ID_W + DIM_W)
    ) u_bnd_ram (
        .aclk    (aclk),
        .wr_en   (bnd_wr_en),
        .wr_addr (bnd_wr_addr),
        .wr_data (bnd_wdata),
        .rd_en   (bnd_rd_en),
        .rd_addr (bnd_rd_addr),
        .rd_data (bnd_rdata)
    );

    adag_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DIM_DEPTH),
        .ADDR_W(ID_W + DIM_W)
    ) u_str_ram (
        .aclk    (aclk),
        .wr_en   (str_wr_en),
        .wr_addr (str_wr_addr),
        .wr_data (str_wdata),
        .rd_en   (str_rd_en),
        .rd_addr ({id_idx, pos_idx}),
        .rd_data (str_rdata)
    );

endmodule

>>> tb/sv/adag_tb_pkg.sv
// ----------------------------------------------------------------------------
// adag_tb_pkg
// word layouts and sizes shared by the address generator testbench
// ----------------------------------------------------------------------------
package adag_tb_pkg;

    import adag_pkg::*;

    localparam int TB_ARRAYS = 16;
    localparam int TB_DIMS   = 8;

    // op code that the block has no use for
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    // input word without the zero pad, array_id in the lowest bits
    typedef struct packed {
        logic [WORD_W-1:0]  subscript;
        logic [WORD_W-1:0]  high_bound;
        logic [WORD_W-1:0]  low_bound;
        logic [POS_W-1:0]   dim_pos;
        logic [TOTAL_W-1:0] dim_total;
        logic [ELEM_W-1:0]  elem_bytes;
        logic [WORD_W-1:0]  base_addr;
        logic [ID_IN_W-1:0] array_id;
    } adag_item_t;

    // result word without the zero pad
    typedef struct packed {
        logic [WORD_W-1:0]  elem_address;
        logic [ID_IN_W-1:0] ref_array;
    } adag_result_t;

    localparam int ITEM_BITS   = $bits(adag_item_t);
    localparam int RESULT_BITS = $bits(adag_result_t);

endpackage

>>> tb/sv/array_address_checker.sv
// ----------------------------------------------------------------------------
// array_address_checker
// watches both streams, keeps its own descriptor table and stride chain,
// predicts each element address and compares it with the result words
// ----------------------------------------------------------------------------
module array_address_checker
    import adag_pkg::*;
    import adag_tb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // array_id, base_addr, elem_bytes, dim_total, dim_pos, low_bound,
    // high_bound, subscript, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // ref_array, elem_address, zero pad
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    addr_pending,
    output int                    addr_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [WORD_W-1:0]  base_tbl   [TB_ARRAYS];
    logic [ELEM_W-1:0]  elem_tbl   [TB_ARRAYS];
    logic [TOTAL_W-1:0] dim_count  [TB_ARRAYS];
    logic               built      [TB_ARRAYS];
    logic [WORD_W-1:0]  origin_tbl [TB_ARRAYS];
    logic [WORD_W-1:0]  lower_tbl  [TB_ARRAYS][TB_DIMS];
    logic [WORD_W-1:0]  extent_tbl [TB_ARRAYS][TB_DIMS];
    logic [WORD_W-1:0]  stride_tbl [TB_ARRAYS][TB_DIMS];
    logic [WORD_W-1:0]  addr_accum;

    adag_result_t addr_q [$];
    int errs = 0;
    int seen = 0;

    initial begin
        fail_count   = 0;
        addr_pending = 0;
        addr_seen    = 0;
    end

    task automatic predict_word(input logic [OP_W-1:0] op, input adag_item_t w);
        logic [ID_IN_W-1:0] id;
        int                 n;
        int                 k;
        logic [WORD_W-1:0]  org;
        adag_result_t       r;
        id = w.array_id;
        n  = int'(dim_count[id]);
        case (op)
            OP_DECL: begin
                base_tbl[id]  = w.base_addr;
                elem_tbl[id]  = w.elem_bytes;
                dim_count[id] = (int'(w.dim_total) > TB_DIMS) ? TOTAL_W'(TB_DIMS) : w.dim_total;
                built[id]     = 1'b0;
                for (k = 0; k < TB_DIMS; k++) begin
                    lower_tbl[id][k]  = '0;
                    extent_tbl[id][k] = '0;
                end
            end
            OP_BOUND: begin
                if (int'(w.dim_pos) < n) begin
                    lower_tbl[id][w.dim_pos]  = w.low_bound;
                    extent_tbl[id][w.dim_pos] = w.high_bound - w.low_bound + 32'd1;
                    // last dimension in: walk the stride chain back to dimension zero
                    if (int'(w.dim_pos) == n - 1) begin
                        k = n - 1;
                        stride_tbl[id][k] = WORD_W'(elem_tbl[id]);
                        org = base_tbl[id] - stride_tbl[id][k] * lower_tbl[id][k];
                        for (k = n - 2; k >= 0; k--) begin
                            stride_tbl[id][k] = stride_tbl[id][k+1] * extent_tbl[id][k+1];
                            org = org - stride_tbl[id][k] * lower_tbl[id][k];
                        end
                        origin_tbl[id] = org;
                        built[id]      = 1'b1;
                    end
                end
            end
            OP_REF: begin
                if (int'(w.dim_pos) < n && built[id]) begin
                    if (w.dim_pos == '0)
                        addr_accum = origin_tbl[id];
                    addr_accum = addr_accum + stride_tbl[id][w.dim_pos] * w.subscript;
                    if (int'(w.dim_pos) == n - 1) begin
                        r.ref_array    = id;
                        r.elem_address = addr_accum;
                        addr_q.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        adag_result_t got;
        adag_result_t want;
        if (!aresetn) begin
            for (int a = 0; a < TB_ARRAYS; a++) begin
                base_tbl[a]   = '0;
                elem_tbl[a]   = '0;
                dim_count[a]  = '0;
                built[a]      = 1'b0;
                origin_tbl[a] = '0;
                for (int d = 0; d < TB_DIMS; d++) begin
                    lower_tbl[a][d]  = '0;
                    extent_tbl[a][d] = '0;
                    stride_tbl[a][d] = '0;
                end
            end
            addr_accum = '0;
            addr_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_word(s_tuser, adag_item_t'(s_tdata[ITEM_BITS-1:0]));
            if (m_tvalid && m_tready) begin
                got = adag_result_t'(m_tdata[RESULT_BITS-1:0]);
                seen++;
                if (addr_q.size() == 0) begin
                    $error("address word with none expected: ref_array %0d elem_address %08h",
                           got.ref_array, got.elem_address);
                    errs++;
                end else begin
                    want = addr_q.pop_front();
                    if (got.ref_array !== want.ref_array) begin
                        $error("ref_array mismatch: expected %0d, actual %0d",
                               want.ref_array, got.ref_array);
                        errs++;
                    end
                    if (got.elem_address !== want.elem_address) begin
                        $error("elem_address mismatch: expected %08h, actual %08h",
                               want.elem_address, got.elem_address);
                        errs++;
                    end
                end
            end
        end
        fail_count   <= errs;
        addr_pending <= addr_q.size();
        addr_seen    <= seen;
    end

endmodule

>>> tb/sv/array_descriptor_address_generator_top_tb.sv
// ----------------------------------------------------------------------------
// array_descriptor_address_generator_top_tb
// declares arrays, sends their bounds and subscripts in bursts with random
// gaps against a stalling receiver; a checker beside the block predicts and
// compares every element address
// ----------------------------------------------------------------------------
module array_descriptor_address_generator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import adag_pkg::*;
    import adag_tb_pkg::*;

    localparam int ITEM_GOAL   = 1950;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 48;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [OP_W-1:0]       s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int addr_pending;
    int addr_seen;

    int burst_left  = 0;
    int words_sent  = 0;
    int noise_sent  = 0;
    int seq_count   = 0;
    int cycle_count = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    logic [OP_W-1:0] op_table [4] = '{OP_DECL, OP_BOUND, OP_REF, OP_NONE};

    always #5 aclk = ~aclk;

    array_descriptor_address_generator_top #(
        .MAX_ARRAYS(TB_ARRAYS),
        .MAX_DIMS  (TB_DIMS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    array_address_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .addr_pending(addr_pending),
        .addr_seen   (addr_seen)
    );

    // receiver: free running, coin flip, mostly stalled, or periodic
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((stall_left % 8) < 5);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d addresses still due", cycle_count,
                     addr_pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return 32'($urandom_range(0, 200)) - 32'd100;
        endcase
    endfunction

    function automatic adag_item_t noise_item();
        adag_item_t w;
        w.array_id   = ID_IN_W'($urandom);
        w.base_addr  = $urandom;
        w.elem_bytes = ELEM_W'($urandom_range(1, 65535));
        w.dim_total  = TOTAL_W'($urandom);
        w.dim_pos    = POS_W'($urandom);
        w.low_bound  = $urandom;
        w.high_bound = $urandom;
        w.subscript  = $urandom;
        return w;
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input adag_item_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(w);
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        burst_left--;
        if (burst_left == 0)
            s_tvalid <= 1'b0;
    endtask

    task automatic decl_array(input logic [ID_IN_W-1:0] id, input logic [WORD_W-1:0] base,
                              input logic [ELEM_W-1:0] elem, input logic [TOTAL_W-1:0] total);
        adag_item_t w;
        w            = noise_item();
        w.array_id   = id;
        w.base_addr  = base;
        w.elem_bytes = elem;
        w.dim_total  = total;
        send_word(OP_DECL, w);
    endtask

    task automatic give_bounds(input logic [ID_IN_W-1:0] id, input logic [POS_W-1:0] pos,
                               input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        adag_item_t w;
        w            = noise_item();
        w.array_id   = id;
        w.dim_pos    = pos;
        w.low_bound  = lo;
        w.high_bound = hi;
        send_word(OP_BOUND, w);
    endtask

    task automatic give_sub(input logic [ID_IN_W-1:0] id, input logic [POS_W-1:0] pos,
                            input logic [WORD_W-1:0] sub);
        adag_item_t w;
        w           = noise_item();
        w.array_id  = id;
        w.dim_pos   = pos;
        w.subscript = sub;
        send_word(OP_REF, w);
    endtask

    initial begin
        logic [ID_IN_W-1:0] id;
        logic [TOTAL_W-1:0] total;
        logic [WORD_W-1:0]  lo;
        logic [WORD_W-1:0]  hi;
        int                 dims;
        int                 first;
        int                 sel;
        bit                 scrambled;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reference on an array never declared, and an unused op
        give_sub(4'd0, 3'd0, 32'd5);
        send_word(OP_NONE, noise_item());
        // zero dimensions gives a declared array that takes no bounds
        decl_array(4'd1, 32'h0000_1000, 16'd4, 4'd0);
        give_bounds(4'd1, 3'd0, 32'd0, 32'd9);
        // one dimension at the extremes, reference before the bounds are complete
        decl_array(4'd2, 32'h8000_0000, 16'd1, 4'd1);
        give_sub(4'd2, 3'd0, 32'd3);
        give_bounds(4'd2, 3'd1, 32'd0, 32'd9);
        give_bounds(4'd2, 3'd0, 32'h8000_0000, 32'h7fff_ffff);
        give_sub(4'd2, 3'd0, 32'h7fff_ffff);
        give_sub(4'd2, 3'd1, 32'd1);
        // too many dimensions, only the last bound given, shared word accumulator
        decl_array(4'd15, 32'hffff_ffff, 16'hffff, 4'd15);
        give_bounds(4'd15, 3'd7, 32'h7fff_ffff, 32'h8000_0000);
        give_sub(4'd15, 3'd7, 32'hffff_ffff);
        give_sub(4'd15, 3'd0, 32'h8000_0000);
        give_bounds(4'd15, 3'd3, 32'hffff_fffb, 32'd5);
        give_bounds(4'd15, 3'd7, 32'd0, 32'd1);
        give_sub(4'd15, 3'd7, 32'd1);
        // a new declaration clears the ready state
        decl_array(4'd2, 32'd0, 16'd8, 4'd2);
        give_sub(4'd2, 3'd1, 32'd2);

        while (words_sent - noise_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(op_table[$urandom_range(0, 3)], noise_item());
                    noise_sent++;
                end
            end else begin
                seq_count++;
                id  = ID_IN_W'($urandom);
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    total = TOTAL_W'($urandom_range(1, 3));
                else if (sel < 9)
                    total = TOTAL_W'($urandom_range(4, 8));
                else
                    total = ($urandom_range(0, 1) == 0) ? 4'd0 : TOTAL_W'($urandom_range(9, 15));
                dims = (int'(total) > TB_DIMS) ? TB_DIMS : int'(total);
                decl_array(id, pick_word(), ELEM_W'($urandom_range(1, 65535)), total);
                if (dims == 0) begin
                    give_sub(id, 3'd0, pick_word());
                    continue;
                end
                scrambled = ($urandom_range(0, 5) == 0);
                for (int p = 0; p < dims; p++) begin
                    if (!scrambled || p == dims - 1 || $urandom_range(0, 1) == 1) begin
                        lo = pick_word();
                        hi = ($urandom_range(0, 3) == 0) ? pick_word()
                                                          : lo + 32'($urandom_range(0, 20));
                        give_bounds(id, POS_W'(p), lo, hi);
                    end
                end
                // late bound after the strides are built: no effect until rebuilt
                if (scrambled && dims > 1)
                    give_bounds(id, POS_W'($urandom_range(0, dims - 2)), pick_word(), pick_word());
                if ($urandom_range(0, 5) == 0)
                    give_bounds(id, POS_W'(dims - 1), pick_word(), pick_word());
                repeat ($urandom_range(1, 4)) begin
                    first = ($urandom_range(0, 7) == 0) ? $urandom_range(0, dims - 1) : 0;
                    for (int p = first; p < dims; p++)
                        give_sub(id, POS_W'(p), pick_word());
                    if (dims < TB_DIMS && $urandom_range(0, 9) == 0)
                        give_sub(id, POS_W'($urandom_range(dims, TB_DIMS - 1)), pick_word());
                end
            end
        end
        if (burst_left != 0)
            s_tvalid <= 1'b0;

        @(posedge aclk);
        while (addr_pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d words (%0d of them noise) over %0d array sequences",
                 words_sent, noise_sent, seq_count);
        $display("checked %0d element addresses, %0d mismatches", addr_seen, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
